// ----- sv/smpq_pkg.sv -----
// smpq_pkg: shared types, codes and defaults of the stable min-priority queue
// used by the interfaces, the controller, the datapath and the top level
package smpq_pkg;

  localparam int DefaultQueueDepth = 16;
  localparam int DefaultPriorityBits = 16;
  localparam int DefaultHandleBits = 32;
  localparam int CountOutBits = 5;
  localparam int StatusBits = 2;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } opcode_e;

  typedef enum logic [StatusBits-1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ENQ_SCAN,
    S_ENQ_HEAD,
    S_FINISH
  } state_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_HEAD,
    RD_LAST,
    RD_PREV
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_NEW_AT_0,
    WR_SHIFT,
    WR_NEW_NEXT
  } wr_sel_e;

  typedef struct packed {
    logic    take_in;
    status_e status;
    logic    cnt_inc;
    logic    pop_head;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic scan_greater;
    logic scan_at_zero;
  } dp_stat_t;

endpackage

// ----- sv/smpq_if.sv -----
// smpq_in_if and smpq_out_if: valid/ready channels of the queue
// depends on smpq_pkg for default widths
interface smpq_in_if #(
  parameter int HANDLE_BITS   = smpq_pkg::DefaultHandleBits,
  parameter int PRIORITY_BITS = smpq_pkg::DefaultPriorityBits
) ();
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [HANDLE_BITS-1:0]   item_handle;
  logic [PRIORITY_BITS-1:0] item_priority;

  modport source (output valid, opcode, item_handle, item_priority, input ready);
  modport sink (input valid, opcode, item_handle, item_priority, output ready);
endinterface

interface smpq_out_if #(
  parameter int HANDLE_BITS   = smpq_pkg::DefaultHandleBits,
  parameter int PRIORITY_BITS = smpq_pkg::DefaultPriorityBits
) ();
  logic                            valid;
  logic                            ready;
  logic [smpq_pkg::StatusBits-1:0] status;
  logic [HANDLE_BITS-1:0]          out_handle;
  logic [PRIORITY_BITS-1:0]        out_priority;
  logic [smpq_pkg::CountOutBits-1:0] entry_count;

  modport source (output valid, status, out_handle, out_priority, entry_count, input ready);
  modport sink (input valid, status, out_handle, out_priority, entry_count, output ready);
endinterface

// ----- sv/smpq_ctrl.sv -----
// smpq_ctrl: sequencer of the queue, issues datapath commands per operation
// depends on smpq_pkg for state, command and status types
module smpq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_opcode_i,
  input  logic               out_ready_i,
  input  smpq_pkg::dp_stat_t stat_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output smpq_pkg::cmd_t     cmd_o
);

  smpq_pkg::state_e  state_q, state_d;
  smpq_pkg::opcode_e op;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  assign op = smpq_pkg::opcode_e'(in_opcode_i);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      smpq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (op == smpq_pkg::OP_ENQUEUE && !stat_i.count_full && !stat_i.count_zero) begin
            state_d = smpq_pkg::S_ENQ_SCAN;
          end else begin
            state_d = smpq_pkg::S_FINISH;
          end
        end
      end
      smpq_pkg::S_ENQ_SCAN: begin
        if (!stat_i.scan_greater) begin
          state_d = smpq_pkg::S_FINISH;
        end else if (stat_i.scan_at_zero) begin
          state_d = smpq_pkg::S_ENQ_HEAD;
        end
      end
      smpq_pkg::S_ENQ_HEAD: begin
        state_d = smpq_pkg::S_FINISH;
      end
      smpq_pkg::S_FINISH: begin
        if (out_free) begin
          state_d = smpq_pkg::S_IDLE;
        end
      end
      default: state_d = smpq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.take_in = 1'b0;
    cmd_o.status = smpq_pkg::ST_ENQUEUED;
    cmd_o.cnt_inc = 1'b0;
    cmd_o.pop_head = 1'b0;
    cmd_o.rd_sel = smpq_pkg::RD_NONE;
    cmd_o.wr_sel = smpq_pkg::WR_NONE;
    cmd_o.load_out = 1'b0;
    unique case (state_q)
      smpq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          if (op == smpq_pkg::OP_DEQUEUE) begin
            if (stat_i.count_zero) begin
              cmd_o.status = smpq_pkg::ST_EMPTY;
            end else begin
              cmd_o.status = smpq_pkg::ST_DEQUEUED;
              cmd_o.rd_sel = smpq_pkg::RD_HEAD;
              cmd_o.pop_head = 1'b1;
            end
          end else if (stat_i.count_full) begin
            cmd_o.status = smpq_pkg::ST_FULL;
          end else begin
            cmd_o.status = smpq_pkg::ST_ENQUEUED;
            cmd_o.cnt_inc = 1'b1;
            if (stat_i.count_zero) begin
              cmd_o.wr_sel = smpq_pkg::WR_NEW_AT_0;
            end else begin
              cmd_o.rd_sel = smpq_pkg::RD_LAST;
            end
          end
        end
      end
      smpq_pkg::S_ENQ_SCAN: begin
        if (stat_i.scan_greater) begin
          cmd_o.wr_sel = smpq_pkg::WR_SHIFT;
          if (!stat_i.scan_at_zero) begin
            cmd_o.rd_sel = smpq_pkg::RD_PREV;
          end
        end else begin
          cmd_o.wr_sel = smpq_pkg::WR_NEW_NEXT;
        end
      end
      smpq_pkg::S_ENQ_HEAD: begin
        cmd_o.wr_sel = smpq_pkg::WR_NEW_AT_0;
      end
      smpq_pkg::S_FINISH: begin
        cmd_o.load_out = out_free;
      end
      default: ;
    endcase
  end

  assign out_valid_d = cmd_o.load_out || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smpq_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // the scan only runs over a queue that already holds entries
  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == smpq_pkg::S_ENQ_SCAN |-> !stat_i.count_zero)
    else $error("enqueue scan over an empty queue");

  // a finished result waits while the output register is blocked
  a_finish_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == smpq_pkg::S_FINISH && out_valid_q && !out_ready_i
      |=> state_q == smpq_pkg::S_FINISH)
    else $error("result dropped while output stalled");

  // a new item is only taken once the previous result has been loaded
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take_in |=> !in_ready_o)
    else $error("second item accepted before result");

endmodule

// ----- sv/smpq_dp.sv -----
// smpq_dp: entry memory kept as a sorted ring, count, scan index and result register
// depends on smpq_pkg for command, status and code types
module smpq_dp #(
  parameter int QUEUE_DEPTH   = smpq_pkg::DefaultQueueDepth,
  parameter int PRIORITY_BITS = smpq_pkg::DefaultPriorityBits,
  parameter int HANDLE_BITS   = smpq_pkg::DefaultHandleBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  smpq_pkg::cmd_t                    cmd_i,
  input  logic [HANDLE_BITS-1:0]            in_handle_i,
  input  logic [PRIORITY_BITS-1:0]          in_priority_i,
  output smpq_pkg::dp_stat_t                stat_o,
  output logic [smpq_pkg::StatusBits-1:0]   out_status_o,
  output logic [HANDLE_BITS-1:0]            out_handle_o,
  output logic [PRIORITY_BITS-1:0]          out_priority_o,
  output logic [smpq_pkg::CountOutBits-1:0] out_count_o
);

  localparam int AddrBits = $clog2(QUEUE_DEPTH);
  localparam int PhysDepth = 1 << AddrBits;
  localparam int CountBits = $clog2(QUEUE_DEPTH + 1);
  localparam int EntryBits = HANDLE_BITS + PRIORITY_BITS;

  logic [EntryBits-1:0]     mem_q [PhysDepth];
  logic [EntryBits-1:0]     rd_q;
  logic [CountBits-1:0]     count_q, count_d;
  logic [AddrBits-1:0]      head_q, head_d;
  logic [AddrBits-1:0]      idx_q, idx_d;
  logic [HANDLE_BITS-1:0]   new_handle_q;
  logic [PRIORITY_BITS-1:0] new_prio_q;
  smpq_pkg::status_e        st_q;

  logic [AddrBits-1:0]      rd_addr, wr_addr;
  logic                     rd_en, wr_en;
  logic [EntryBits-1:0]     wr_data, new_entry;
  logic [PRIORITY_BITS-1:0] new_prio;

  assign new_prio  = cmd_i.take_in ? in_priority_i : new_prio_q;
  assign new_entry = cmd_i.take_in ? {in_handle_i, in_priority_i} : {new_handle_q, new_prio_q};

  assign rd_en = cmd_i.rd_sel != smpq_pkg::RD_NONE;
  assign wr_en = cmd_i.wr_sel != smpq_pkg::WR_NONE;

  always_comb begin
    idx_d = idx_q;
    unique case (cmd_i.rd_sel)
      smpq_pkg::RD_NONE: rd_addr = head_q;
      smpq_pkg::RD_HEAD: rd_addr = head_q;
      smpq_pkg::RD_LAST: begin
        idx_d = AddrBits'(count_q - CountBits'(1));
        rd_addr = head_q + idx_d;
      end
      smpq_pkg::RD_PREV: begin
        idx_d = idx_q - AddrBits'(1);
        rd_addr = head_q + idx_d;
      end
      default: rd_addr = head_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wr_sel)
      smpq_pkg::WR_NONE: begin
        wr_addr = head_q;
        wr_data = new_entry;
      end
      smpq_pkg::WR_NEW_AT_0: begin
        wr_addr = head_q;
        wr_data = new_entry;
      end
      smpq_pkg::WR_SHIFT: begin
        wr_addr = head_q + idx_q + AddrBits'(1);
        wr_data = rd_q;
      end
      smpq_pkg::WR_NEW_NEXT: begin
        wr_addr = head_q + idx_q + AddrBits'(1);
        wr_data = new_entry;
      end
      default: begin
        wr_addr = head_q;
        wr_data = new_entry;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    count_d = count_q;
    head_d = head_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CountBits'(1);
    end else if (cmd_i.pop_head) begin
      count_d = count_q - CountBits'(1);
      head_d = head_q + AddrBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      head_q <= '0;
    end else begin
      count_q <= count_d;
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.take_in) begin
      new_handle_q <= in_handle_i;
      new_prio_q <= in_priority_i;
      st_q <= cmd_i.status;
    end
    if (cmd_i.load_out) begin
      out_status_o <= st_q;
      out_count_o <= smpq_pkg::CountOutBits'(count_q);
      if (st_q == smpq_pkg::ST_DEQUEUED) begin
        out_handle_o <= rd_q[EntryBits-1:PRIORITY_BITS];
        out_priority_o <= rd_q[PRIORITY_BITS-1:0];
      end else begin
        out_handle_o <= '0;
        out_priority_o <= '0;
      end
    end
  end

  assign stat_o.count_zero   = count_q == '0;
  assign stat_o.count_full   = count_q == CountBits'(QUEUE_DEPTH);
  assign stat_o.scan_greater = rd_q[PRIORITY_BITS-1:0] > new_prio;
  assign stat_o.scan_at_zero = idx_q == '0;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountBits'(QUEUE_DEPTH))
    else $error("entry count above depth");

  // the shift writes two slots above the slot being fetched
  a_no_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en && wr_en |-> rd_addr != wr_addr)
    else $error("read and write at the same slot");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_head |=> count_q == $past(count_q) - CountBits'(1))
    else $error("dequeue did not lower the count");

endmodule

// ----- sv/stable_min_priority_queue_top.sv -----
// stable_min_priority_queue_top: bounded min-priority queue, equal priorities leave FIFO
// depends on smpq_pkg, smpq_if, smpq_ctrl and smpq_dp
//
// in_i carries one operation per transfer: opcode 0 enqueues (item_handle,
// item_priority), opcode 1 dequeues the head. out_o returns exactly one
// result per operation: status, the removed handle and priority (zero
// unless dequeued) and the entry count after the operation.
// Entries sit in a single dual-port memory used as a sorted ring; a dequeue
// advances the head pointer, an enqueue moves larger entries up one slot at
// a time, starting from the tail, through the single write port.
// From acceptance, a dequeue, a full or empty status, or an enqueue into an
// empty queue goes through the finish state to the result register; an
// enqueue into a non-empty queue first passes the scan state once for each
// entry that holds a larger priority, then one more scan or head state,
// whether or not the new entry becomes the head. One operation is in flight
// at a time; in_i.ready is high again in the same cycle that its result is
// in the output register. A result waiting on a stalled receiver does not
// block the next operation, but a second finished result waits inside
// until out_o.ready frees the register.
// Reset empties the queue at once; no clearing pass over the memory.
module stable_min_priority_queue_top #(
  parameter int QUEUE_DEPTH   = smpq_pkg::DefaultQueueDepth,
  parameter int PRIORITY_BITS = smpq_pkg::DefaultPriorityBits,
  parameter int HANDLE_BITS   = smpq_pkg::DefaultHandleBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  smpq_in_if.sink     in_i,
  smpq_out_if.source  out_o
);

  smpq_pkg::cmd_t     cmd;
  smpq_pkg::dp_stat_t stat;

  smpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.opcode),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  smpq_dp #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS),
    .HANDLE_BITS   (HANDLE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .in_handle_i    (in_i.item_handle),
    .in_priority_i  (in_i.item_priority),
    .stat_o         (stat),
    .out_status_o   (out_o.status),
    .out_handle_o   (out_o.out_handle),
    .out_priority_o (out_o.out_priority),
    .out_count_o    (out_o.entry_count)
  );

endmodule

// ----- tb/tb_stable_min_priority_queue_top.sv -----
// tb_stable_min_priority_queue_top: self-checking testbench of the stable min-priority queue
// depends on smpq_pkg, smpq_if and stable_min_priority_queue_top
// a sorted-list predictor checks every result transfer; random stalls on both channels
module tb_stable_min_priority_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QueueDepth = smpq_pkg::DefaultQueueDepth;
  localparam int HandleBits = smpq_pkg::DefaultHandleBits;
  localparam int PrioBits   = smpq_pkg::DefaultPriorityBits;
  localparam int RandomOps  = 950;
  localparam int QuietOps   = 100;
  localparam int SettleCycles = 60;

  typedef struct {
    smpq_pkg::opcode_e     op;
    logic [HandleBits-1:0] hdl;
    logic [PrioBits-1:0]   prio;
    bit                    wait_drain;
    bit                    quiet;
  } queue_op_t;

  typedef struct {
    logic [HandleBits-1:0] hdl;
    logic [PrioBits-1:0]   prio;
  } entry_t;

  typedef struct {
    smpq_pkg::status_e                 status;
    logic [HandleBits-1:0]             hdl;
    logic [PrioBits-1:0]               prio;
    logic [smpq_pkg::CountOutBits-1:0] count;
  } queue_result_t;

  logic clk_i;
  logic rst_ni;

  smpq_in_if  #(.HANDLE_BITS(HandleBits), .PRIORITY_BITS(PrioBits)) in_ch ();
  smpq_out_if #(.HANDLE_BITS(HandleBits), .PRIORITY_BITS(PrioBits)) out_ch ();

  stable_min_priority_queue_top #(
    .QUEUE_DEPTH  (QueueDepth),
    .PRIORITY_BITS(PrioBits),
    .HANDLE_BITS  (HandleBits)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  queue_op_t     pending_ops[$];
  queue_result_t expected_results[$];
  entry_t        sorted_entries[$];
  queue_op_t     cur_op;

  int  gap_left;
  int  stall_left;
  bit  quiet_phase;
  int  mismatches;
  int  results_seen;
  int  n_enqueued, n_dequeued, n_empty, n_full;
  int  peak_fill;

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = smpq_pkg::OP_ENQUEUE;
    in_ch.item_handle = '0;
    in_ch.item_priority = '0;
    out_ch.ready = 1'b0;
    gap_left = 0;
    stall_left = 0;
    quiet_phase = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch in result %0d, %s: got 0x%0h, expected 0x%0h",
             results_seen, field, got, want);
  endtask

  // sorted insert after all entries of lower or equal priority, dequeue pops the front
  task automatic apply_to_model(input queue_op_t op);
    queue_result_t res;
    entry_t        ent;
    int            pos;
    res.hdl = '0;
    res.prio = '0;
    if (op.op == smpq_pkg::OP_ENQUEUE) begin
      if (sorted_entries.size() >= QueueDepth) begin
        res.status = smpq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < sorted_entries.size() && sorted_entries[pos].prio <= op.prio) pos++;
        ent.hdl = op.hdl;
        ent.prio = op.prio;
        sorted_entries.insert(pos, ent);
        res.status = smpq_pkg::ST_ENQUEUED;
      end
    end else begin
      if (sorted_entries.size() == 0) begin
        res.status = smpq_pkg::ST_EMPTY;
      end else begin
        ent = sorted_entries.pop_front();
        res.hdl = ent.hdl;
        res.prio = ent.prio;
        res.status = smpq_pkg::ST_DEQUEUED;
      end
    end
    res.count = smpq_pkg::CountOutBits'(sorted_entries.size());
    if (sorted_entries.size() > peak_fill) peak_fill = sorted_entries.size();
    expected_results.push_back(res);
  endtask

  task automatic add_op(input smpq_pkg::opcode_e op, input logic [HandleBits-1:0] hdl,
                        input logic [PrioBits-1:0] prio, input bit wait_drain);
    queue_op_t item;
    item.op = op;
    item.hdl = hdl;
    item.prio = prio;
    item.wait_drain = wait_drain;
    item.quiet = 1'b0;
    pending_ops.push_back(item);
  endtask

  function automatic logic [PrioBits-1:0] pick_prio(input int mode);
    case (mode)
      0: pick_prio = PrioBits'($urandom);
      1: pick_prio = PrioBits'($urandom_range(0, 3));
      2: begin
        case ($urandom_range(0, 3))
          0: pick_prio = '0;
          1: pick_prio = '1;
          2: pick_prio = PrioBits'(1);
          default: pick_prio = {{(PrioBits-1){1'b1}}, 1'b0};
        endcase
      end
      default: pick_prio = PrioBits'($urandom_range(100, 120));
    endcase
  endfunction

  // sender: one transfer per accepted item, random idle bursts
  always @(posedge clk_i) begin : driver
    queue_op_t nxt;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) apply_to_model(cur_op);
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_ops.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else if (pending_ops[0].wait_drain && expected_results.size() != 0) begin
          in_ch.valid <= 1'b0;
        end else if (!pending_ops[0].quiet && $urandom_range(0, 5) == 0) begin
          gap_left <= $urandom_range(0, 9);
          in_ch.valid <= 1'b0;
        end else begin
          nxt = pending_ops.pop_front();
          cur_op = nxt;
          if (nxt.quiet) quiet_phase <= 1'b1;
          in_ch.valid <= 1'b1;
          in_ch.opcode <= nxt.op;
          in_ch.item_handle <= nxt.hdl;
          in_ch.item_priority <= nxt.prio;
        end
      end
    end
  end

  // receiver: checks each result transfer against the oldest expectation
  always @(posedge clk_i) begin : monitor
    queue_result_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_ch.status, 0);
        end else begin
          want = expected_results.pop_front();
          case (want.status)
            smpq_pkg::ST_ENQUEUED: n_enqueued++;
            smpq_pkg::ST_DEQUEUED: n_dequeued++;
            smpq_pkg::ST_EMPTY:    n_empty++;
            default:               n_full++;
          endcase
          if (out_ch.status !== want.status)
            report_mismatch("status", out_ch.status, want.status);
          if (out_ch.out_handle !== want.hdl)
            report_mismatch("out_handle", out_ch.out_handle, want.hdl);
          if (out_ch.out_priority !== want.prio)
            report_mismatch("out_priority", out_ch.out_priority, want.prio);
          if (out_ch.entry_count !== want.count)
            report_mismatch("entry_count", out_ch.entry_count, want.count);
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 9);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int                produced;
    int                phase;
    int                phase_len;
    int                enq_pct;
    int                prio_mode;
    smpq_pkg::opcode_e op;

    // empty dequeue, field extremes, ties at both ends, fill to full
    add_op(smpq_pkg::OP_DEQUEUE, '1, '1, 1'b0);
    add_op(smpq_pkg::OP_ENQUEUE, '1, '1, 1'b0);
    add_op(smpq_pkg::OP_ENQUEUE, '0, '0, 1'b0);
    add_op(smpq_pkg::OP_ENQUEUE, 32'h0000_1234, 16'h8000, 1'b0);
    add_op(smpq_pkg::OP_ENQUEUE, 32'h5555_5555, 16'h8000, 1'b0);
    add_op(smpq_pkg::OP_ENQUEUE, 32'hAAAA_AAAA, 16'h0000, 1'b0);
    add_op(smpq_pkg::OP_ENQUEUE, 32'h8000_0001, 16'hFFFF, 1'b0);
    for (int i = 0; i < 10; i++)
      add_op(smpq_pkg::OP_ENQUEUE, 32'h100 + i, 16'h0007, 1'b0);
    // enqueue while full
    add_op(smpq_pkg::OP_ENQUEUE, 32'hDEAD_BEEF, 16'h0001, 1'b0);
    add_op(smpq_pkg::OP_DEQUEUE, '1, '1, 1'b0);
    add_op(smpq_pkg::OP_DEQUEUE, '0, '0, 1'b0);
    add_op(smpq_pkg::OP_DEQUEUE, 32'h0F0F_0F0F, 16'h00FF, 1'b0);

    produced = 0;
    phase = 0;
    while (produced < RandomOps) begin
      phase_len = $urandom_range(20, 60);
      case ($urandom_range(0, 4))
        0: enq_pct = 90;
        1: enq_pct = 70;
        2: enq_pct = 50;
        3: enq_pct = 30;
        default: enq_pct = 10;
      endcase
      prio_mode = $urandom_range(0, 3);
      for (int i = 0; i < phase_len && produced < RandomOps; i++) begin
        op = ($urandom_range(0, 99) < enq_pct) ? smpq_pkg::OP_ENQUEUE : smpq_pkg::OP_DEQUEUE;
        // sender holds off until all results are back at some phase starts
        add_op(op, HandleBits'($urandom), pick_prio(prio_mode), (i == 0) && (phase % 4 == 0));
        produced++;
      end
      phase++;
    end
    for (int i = pending_ops.size() - QuietOps; i < pending_ops.size(); i++) begin
      pending_ops[i].quiet = 1'b1;
      pending_ops[i].wait_drain = 1'b0;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (pending_ops.size() != 0 || in_ch.valid);
    do @(posedge clk_i); while (expected_results.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);

    if (expected_results.size() != 0)
      report_mismatch("missing results", 0, expected_results.size());

    $display("%0d results checked: %0d enqueued, %0d dequeued, %0d on empty, %0d on full",
             results_seen, n_enqueued, n_dequeued, n_empty, n_full);
    $display("queue fill reached %0d of %0d entries, %0d mismatches",
             peak_fill, QueueDepth, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/smpq_pkg.sv
sv/smpq_if.sv
sv/smpq_ctrl.sv
sv/smpq_dp.sv
sv/stable_min_priority_queue_top.sv
tb/tb_stable_min_priority_queue_top.sv
